@@ hw/rtl/sfkh_pkg.sv @@
`default_nettype none

package sfkh_pkg;

  // Key layout
  localparam int unsigned KeyWords   = 11;
  localparam int unsigned KeyWordsV4 = 5;
  localparam int unsigned KeyWordsV6 = 11;

  // Pipeline depth: normalize, three mixes of two stages each, final in two stages
  localparam int unsigned NumStages = 9;

  // lookup3 start value, with the length term folded in per key size
  localparam logic [31:0] Lookup3Init = 32'hdeadbeef;
  localparam logic [31:0] InitV4 = Lookup3Init + 32'(KeyWordsV4 * 4);
  localparam logic [31:0] InitV6 = Lookup3Init + 32'(KeyWordsV6 * 4);

  typedef logic [KeyWords-1:0][31:0] sfkh_key_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } sfkh_abc_t;

  typedef struct packed {
    logic      v6;
    sfkh_abc_t abc;
    sfkh_key_t key;
  } sfkh_stage_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // First three steps of the lookup3 mix
  function automatic sfkh_abc_t mix_h1(input sfkh_abc_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    sfkh_abc_t   r;
    a = s.a;
    b = s.b;
    c = s.c;
    a = a - c; a = a ^ rotl(c, 4); c = c + b;
    b = b - a; b = b ^ rotl(a, 6); a = a + c;
    c = c - b; c = c ^ rotl(b, 8); b = b + a;
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  // Last three steps of the lookup3 mix
  function automatic sfkh_abc_t mix_h2(input sfkh_abc_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    sfkh_abc_t   r;
    a = s.a;
    b = s.b;
    c = s.c;
    a = a - c; a = a ^ rotl(c, 16); c = c + b;
    b = b - a; b = b ^ rotl(a, 19); a = a + c;
    c = c - b; c = c ^ rotl(b, 4);  b = b + a;
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  // First four steps of the lookup3 final
  function automatic sfkh_abc_t final_h1(input sfkh_abc_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    sfkh_abc_t   r;
    a = s.a;
    b = s.b;
    c = s.c;
    c = c ^ b; c = c - rotl(b, 14);
    a = a ^ c; a = a - rotl(c, 11);
    b = b ^ a; b = b - rotl(a, 25);
    c = c ^ b; c = c - rotl(b, 16);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  // Last three steps of the lookup3 final
  function automatic sfkh_abc_t final_h2(input sfkh_abc_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    sfkh_abc_t   r;
    a = s.a;
    b = s.b;
    c = s.c;
    a = a ^ c; a = a - rotl(c, 4);
    b = b ^ a; b = b - rotl(a, 14);
    c = c ^ b; c = c - rotl(b, 24);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sfkh_norm.sv @@
`default_nettype none

// Builds the direction-independent key words from one tuple.
// IPv4 words sit in slots 0..2, 9, 10 so both key sizes share the final add.
module sfkh_norm (
  input  logic              is_ipv6_i,
  input  logic [63:0]       src_addr_high_i,
  input  logic [63:0]       src_addr_low_i,
  input  logic [63:0]       dst_addr_high_i,
  input  logic [63:0]       dst_addr_low_i,
  input  logic [15:0]       src_port_i,
  input  logic [15:0]       dst_port_i,
  input  logic [7:0]        protocol_i,
  input  logic [7:0]        tunnel_level_i,
  input  logic [11:0]       vlan_outer_i,
  input  logic [11:0]       vlan_inner_i,
  output sfkh_pkg::sfkh_key_t key_o
);
  import sfkh_pkg::*;

  logic [127:0] src_addr;
  logic [127:0] dst_addr;
  logic [127:0] first_addr;
  logic [127:0] other_addr;
  logic         src_first;
  logic [31:0]  v4_lo;
  logic [31:0]  v4_hi;
  logic [15:0]  port_lo;
  logic [15:0]  port_hi;
  logic [31:0]  tail0;
  logic [31:0]  tail1;
  logic [31:0]  tail2;

  assign src_addr = {src_addr_high_i, src_addr_low_i};
  assign dst_addr = {dst_addr_high_i, dst_addr_low_i};

  // Word 0 is most significant, so a wide compare orders like word by word
  assign src_first  = src_addr > dst_addr;
  assign first_addr = src_first ? src_addr : dst_addr;
  assign other_addr = src_first ? dst_addr : src_addr;

  // IPv4 uses address word 0 only, smaller first
  assign v4_lo = (src_addr_high_i[63:32] < dst_addr_high_i[63:32]) ?
                 src_addr_high_i[63:32] : dst_addr_high_i[63:32];
  assign v4_hi = (src_addr_high_i[63:32] < dst_addr_high_i[63:32]) ?
                 dst_addr_high_i[63:32] : src_addr_high_i[63:32];

  // Ports smaller first, first half in bits 15:0
  assign port_lo = (src_port_i < dst_port_i) ? src_port_i : dst_port_i;
  assign port_hi = (src_port_i < dst_port_i) ? dst_port_i : src_port_i;
  assign tail0   = {port_hi, port_lo};
  assign tail1   = {8'h00, tunnel_level_i, 8'h00, protocol_i};
  assign tail2   = {4'h0, vlan_inner_i, 4'h0, vlan_outer_i};

  always_comb begin
    key_o = '0;
    if (is_ipv6_i) begin
      key_o[0] = first_addr[127:96];
      key_o[1] = first_addr[95:64];
      key_o[2] = first_addr[63:32];
      key_o[3] = first_addr[31:0];
      key_o[4] = other_addr[127:96];
      key_o[5] = other_addr[95:64];
      key_o[6] = other_addr[63:32];
      key_o[7] = other_addr[31:0];
      key_o[8] = tail0;
    end else begin
      key_o[0] = v4_lo;
      key_o[1] = v4_hi;
      key_o[2] = tail0;
    end
    key_o[9]  = tail1;
    key_o[10] = tail2;
  end

endmodule

`default_nettype wire

@@ hw/rtl/symmetric_flow_key_hash.sv @@
`default_nettype none

// Channel   | Handshake                  | Word
// ----------+----------------------------+----------------------------------------
// tuple in  | start_i, busy_o            | is_ipv6_i, addresses, ports, proto, vlans
// hash out  | flow_valid_o (strobe)      | key_hash_o
// seed cfg  | cfg_valid_i, cfg_ready_o   | cfg_data_i
//
// One tuple per cycle while busy_o is low; each hash comes out of the
// 9-stage pipeline (normalize, three lookup3 mixes of two stages each, final in
// two stages). IPv4 tuples pass the second and third mix untouched.
// busy_o is high during reset and the first cycle after it; the result strobe
// cannot be held off, so the pipeline never stalls. The seed is read when a
// tuple enters.
module symmetric_flow_key_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        is_ipv6_i,
  input  logic [63:0] src_addr_high_i,
  input  logic [63:0] src_addr_low_i,
  input  logic [63:0] dst_addr_high_i,
  input  logic [63:0] dst_addr_low_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  protocol_i,
  input  logic [7:0]  tunnel_level_i,
  input  logic [11:0] vlan_outer_i,
  input  logic [11:0] vlan_inner_i,
  output logic        flow_valid_o,
  output logic [31:0] key_hash_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import sfkh_pkg::*;

  logic                  busy_q;
  logic [31:0]           seed_q;
  logic [31:0]           seed_d;
  sfkh_key_t             norm_key;
  sfkh_stage_t           pipe_d [NumStages];
  sfkh_stage_t           pipe_q [NumStages];
  logic [NumStages-1:0]  valid_d;
  logic [NumStages-1:0]  valid_q;

  // Ready once out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;

  // Seed register
  assign seed_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  // Key normalization
  sfkh_norm u_norm (
    .is_ipv6_i       (is_ipv6_i),
    .src_addr_high_i (src_addr_high_i),
    .src_addr_low_i  (src_addr_low_i),
    .dst_addr_high_i (dst_addr_high_i),
    .dst_addr_low_i  (dst_addr_low_i),
    .src_port_i      (src_port_i),
    .dst_port_i      (dst_port_i),
    .protocol_i      (protocol_i),
    .tunnel_level_i  (tunnel_level_i),
    .vlan_outer_i    (vlan_outer_i),
    .vlan_inner_i    (vlan_inner_i),
    .key_o           (norm_key)
  );

  // Stage work: entry, then mix and final halves
  always_comb begin
    sfkh_stage_t st;
    pipe_d[0].v6    = is_ipv6_i;
    pipe_d[0].key   = norm_key;
    pipe_d[0].abc.a = (is_ipv6_i ? InitV6 : InitV4) + seed_q;
    pipe_d[0].abc.b = pipe_d[0].abc.a;
    pipe_d[0].abc.c = pipe_d[0].abc.a;
    for (int s = 1; s < NumStages; s++) begin
      st = pipe_q[s-1];
      case (s)
        1: begin
          st.abc.a = st.abc.a + st.key[0];
          st.abc.b = st.abc.b + st.key[1];
          st.abc.c = st.abc.c + st.key[2];
          st.abc   = mix_h1(st.abc);
        end
        2: st.abc = mix_h2(st.abc);
        3: begin
          if (st.v6) begin
            st.abc.a = st.abc.a + st.key[3];
            st.abc.b = st.abc.b + st.key[4];
            st.abc.c = st.abc.c + st.key[5];
            st.abc   = mix_h1(st.abc);
          end
        end
        4: begin
          if (st.v6) begin
            st.abc = mix_h2(st.abc);
          end
        end
        5: begin
          if (st.v6) begin
            st.abc.a = st.abc.a + st.key[6];
            st.abc.b = st.abc.b + st.key[7];
            st.abc.c = st.abc.c + st.key[8];
            st.abc   = mix_h1(st.abc);
          end
        end
        6: begin
          if (st.v6) begin
            st.abc = mix_h2(st.abc);
          end
        end
        // Two words remain for both key sizes
        7: begin
          st.abc.a = st.abc.a + st.key[9];
          st.abc.b = st.abc.b + st.key[10];
          st.abc   = final_h1(st.abc);
        end
        8: st.abc = final_h2(st.abc);
        default: st = pipe_q[s-1];
      endcase
      pipe_d[s] = st;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStages; s++) begin
      pipe_q[s] <= pipe_d[s];
    end
  end

  // Valid bits follow the words
  assign valid_d = {valid_q[NumStages-2:0], start_i && !busy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign flow_valid_o = valid_q[NumStages-1];
  assign key_hash_o   = pipe_q[NumStages-1].abc.c;

endmodule

`default_nettype wire

@@ hw/rtl/sfkh_checker.sv @@
`default_nettype none

module sfkh_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  wire        busy_o,
  input  wire        is_ipv6_i,
  input  wire [63:0] src_addr_high_i,
  input  wire [63:0] src_addr_low_i,
  input  wire [63:0] dst_addr_high_i,
  input  wire [63:0] dst_addr_low_i,
  input  wire [15:0] src_port_i,
  input  wire [15:0] dst_port_i,
  input  wire [7:0]  protocol_i,
  input  wire [7:0]  tunnel_level_i,
  input  wire [11:0] vlan_outer_i,
  input  wire [11:0] vlan_inner_i,
  input  wire        flow_valid_o,
  input  wire [31:0] key_hash_o,
  input  wire        cfg_valid_i,
  input  wire        cfg_ready_o,
  input  wire [31:0] cfg_data_i
);
  import sfkh_pkg::*;

  localparam int unsigned TupleBits = 329;

  logic                 acc;
  logic                 cfg_fire;
  logic                 swapped;
  logic [TupleBits-1:0] tuple_d;
  logic [TupleBits-1:0] tuple_rev;
  logic [TupleBits-1:0] tuple_q;

  assign acc      = start_i && !busy_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // Tuple as seen, and seen from the other direction
  assign tuple_d   = {is_ipv6_i, src_addr_high_i, src_addr_low_i, dst_addr_high_i,
                      dst_addr_low_i, src_port_i, dst_port_i, protocol_i, tunnel_level_i,
                      vlan_outer_i, vlan_inner_i};
  assign tuple_rev = {is_ipv6_i, dst_addr_high_i, dst_addr_low_i, src_addr_high_i,
                      src_addr_low_i, dst_port_i, src_port_i, protocol_i, tunnel_level_i,
                      vlan_outer_i, vlan_inner_i};

  always_ff @(posedge clk_i) begin
    tuple_q <= tuple_d;
  end

  // Current tuple is the previous one seen from the other direction
  assign swapped = (tuple_rev == tuple_q);

  // Every accepted tuple yields a hash after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##(NumStages) flow_valid_o)
    else $error("accepted tuple gave no hash");

  // No hash without a tuple accepted the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow_valid_o |-> $past(acc, NumStages))
    else $error("hash without a tuple");

  // Reversed direction on back-to-back tuples gives the same hash
  a_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && $past(acc) && $past(rst_ni) && !$past(cfg_fire) && swapped)
      |-> ##(NumStages) (key_hash_o == $past(key_hash_o)))
    else $error("hash depends on direction");

endmodule

bind symmetric_flow_key_hash sfkh_checker u_sfkh_checker (.*);

`default_nettype wire
